// ----- design/ncp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncp_pkg: shared types and constants of the notify coalescing policy
// register map, reset values, mode codes and payload widths
// ----------------------------------------------------------------------------
package ncp_pkg;

  // statistic counter width default
  localparam int unsigned STAT_WIDTH_DEF = 32;

  // payload widths
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned PEND_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned BYTE_W    = 48;
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned IN_DATA_W = 16;
  // notify, by_timer, pending, packets, bytes, calls, batch, immediate = 194, padded
  localparam int unsigned OUT_DATA_W = 200;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_NOTIFY_MODE      = 3'd0,
    REG_PACKET_THRESHOLD = 3'd1,
    REG_TIME_THRESHOLD   = 3'd2,
    REG_LARGE_SIZE       = 3'd3,
    REG_SMALL_SIZE       = 3'd4,
    REG_BYPASS           = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IMMEDIATE = 2'd0,
    MODE_COUNT     = 2'd1,
    MODE_TIME      = 2'd2,
    MODE_ADAPTIVE  = 2'd3
  } mode_t;

  // input kind carried on tuser
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // register reset values
  localparam logic [15:0] PACKET_THRESHOLD_RST = 16'd16;
  localparam logic [15:0] TIME_THRESHOLD_RST   = 16'd100;
  localparam logic [15:0] LARGE_SIZE_RST       = 16'd1024;
  localparam logic [15:0] SMALL_SIZE_RST       = 16'd128;

  localparam logic [PEND_W-1:0] PENDING_MAX = '1;

endpackage

// ----- design/notify_coalescing_policy_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notify_coalescing_policy_top: notification coalescing decision engine
// decides per packet or tick whether the sender notifies its peer
// ----------------------------------------------------------------------------
// usage
//   in_*  : one item per handshake; in_tuser is the kind (0 packet sent,
//           1 time tick), in_tdata carries the packet size in bytes
//   out_* : one result item per input item, in order; out_tdata packs
//           notify, by_timer, pending count and the statistic totals
//   cfg_* : register port, regs at byte address 4*i: mode, packet
//           threshold, time threshold, large size, small size, bypass;
//           write only while the block is idle
// timing
//   the decision and all state updates happen at the accepting edge, and the
//   result is loaded into the output register at that same edge
//   throughput is one item per cycle unless stalled, set by the single
//   state update path (elapsed-time subtract, compare, counter increments)
// reset
//   rst_n low clears all counters, the timer and the output valid, and
//   loads the register reset values
// back pressure
//   while out_tready is low with a result held, in_tready drops; it rises
//   in the same cycle the held result is taken
// ----------------------------------------------------------------------------
module notify_coalescing_policy_top
  import ncp_pkg::*;
#(
  parameter int unsigned STAT_WIDTH = STAT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] packet_size
  input  logic                  in_tuser,   // [0] op
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] notify, [1] by_timer, [17:2] pending_count, [49:18] packet_total,
  // [97:50] byte_total, [129:98] call_total, [161:130] batch_notify_total,
  // [193:162] immediate_notify_total, [199:194] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]  notify_mode_r;
  logic [15:0] packet_threshold_r;
  logic [15:0] time_threshold_r;
  logic [15:0] large_size_r;
  logic [15:0] small_size_r;
  logic        bypass_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notify_mode_r      <= MODE_IMMEDIATE;
      packet_threshold_r <= PACKET_THRESHOLD_RST;
      time_threshold_r   <= TIME_THRESHOLD_RST;
      large_size_r       <= LARGE_SIZE_RST;
      small_size_r       <= SMALL_SIZE_RST;
      bypass_r           <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NOTIFY_MODE:      notify_mode_r      <= cfg_pwdata[1:0];
        REG_PACKET_THRESHOLD: packet_threshold_r <= cfg_pwdata[15:0];
        REG_TIME_THRESHOLD:   time_threshold_r   <= cfg_pwdata[15:0];
        REG_LARGE_SIZE:       large_size_r       <= cfg_pwdata[15:0];
        REG_SMALL_SIZE:       small_size_r       <= cfg_pwdata[15:0];
        REG_BYPASS:           bypass_r           <= cfg_pwdata[0];
        default: ;  // unmapped addresses are ignored
      endcase
    end
  end

  // register readback
  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_NOTIFY_MODE:      cfg_prdata[1:0]  = notify_mode_r;
      REG_PACKET_THRESHOLD: cfg_prdata[15:0] = packet_threshold_r;
      REG_TIME_THRESHOLD:   cfg_prdata[15:0] = time_threshold_r;
      REG_LARGE_SIZE:       cfg_prdata[15:0] = large_size_r;
      REG_SMALL_SIZE:       cfg_prdata[15:0] = small_size_r;
      REG_BYPASS:           cfg_prdata[0]    = bypass_r;
      default:              cfg_prdata       = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // policy state
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]     time_now_r,    time_now_nxt;
  logic [TIME_W-1:0]     last_notify_r, last_notify_nxt;
  logic [PEND_W-1:0]     pending_r,     pending_nxt;
  logic                  timer_armed_r, timer_armed_nxt;
  logic [15:0]           timer_rem_r,   timer_rem_nxt;
  logic [STAT_WIDTH-1:0] packets_r,     packets_nxt;
  logic [BYTE_W-1:0]     bytes_r,       bytes_nxt;
  logic [STAT_WIDTH-1:0] calls_r,       calls_nxt;
  logic [STAT_WIDTH-1:0] batch_r,       batch_nxt;
  logic [STAT_WIDTH-1:0] immed_r,       immed_nxt;

  logic              in_accept;
  logic              notify_nxt;
  logic              by_timer_nxt;
  logic [15:0]       size;
  logic [PEND_W-1:0] pend_inc;
  logic [TIME_W-1:0] elapsed;
  logic              fire;
  mode_t             mode;

  assign in_accept = in_tvalid && in_tready;
  assign size      = in_tdata[SIZE_W-1:0];
  assign mode      = mode_t'(notify_mode_r);
  assign pend_inc  = (pending_r == PENDING_MAX) ? pending_r : pending_r + 1'b1;
  assign elapsed   = time_now_r - last_notify_r;

  // per-mode notify decision for a packet
  always_comb begin
    case (mode)
      MODE_IMMEDIATE: fire = 1'b1;
      MODE_COUNT:     fire = (pend_inc >= packet_threshold_r);
      MODE_TIME:      fire = (elapsed >= {16'd0, time_threshold_r});
      MODE_ADAPTIVE:  fire = (size >= large_size_r) || (size < small_size_r) ||
                             (pend_inc >= packet_threshold_r) ||
                             (elapsed >= {16'd0, time_threshold_r});
      default:        fire = 1'b1;
    endcase
  end

  always_comb begin
    time_now_nxt    = time_now_r;
    last_notify_nxt = last_notify_r;
    pending_nxt     = pending_r;
    timer_armed_nxt = timer_armed_r;
    timer_rem_nxt   = timer_rem_r;
    packets_nxt     = packets_r;
    bytes_nxt       = bytes_r;
    calls_nxt       = calls_r;
    batch_nxt       = batch_r;
    immed_nxt       = immed_r;
    notify_nxt      = 1'b0;
    by_timer_nxt    = 1'b0;

    if (in_tuser == OP_TICK) begin
      time_now_nxt = time_now_r + 1'b1;
      if (timer_armed_r) begin
        if (timer_rem_r <= 16'd1) begin
          // one-shot timer expires
          timer_rem_nxt   = '0;
          timer_armed_nxt = 1'b0;
          if (pending_r != '0) begin
            pending_nxt     = '0;
            last_notify_nxt = time_now_nxt;
            batch_nxt       = batch_r + 1'b1;
            notify_nxt      = 1'b1;
            by_timer_nxt    = 1'b1;
          end
        end else begin
          timer_rem_nxt = timer_rem_r - 1'b1;
        end
      end
    end else if (bypass_r) begin
      // bypass notifies and leaves all state alone
      notify_nxt = 1'b1;
    end else begin
      pending_nxt = pend_inc;
      packets_nxt = packets_r + 1'b1;
      bytes_nxt   = bytes_r + {{(BYTE_W-SIZE_W){1'b0}}, size};
      calls_nxt   = calls_r + 1'b1;
      // first pending packet arms the batch timer in time-based modes
      if (!fire && notify_mode_r[1] && (pend_inc == 16'd1) && !timer_armed_r) begin
        timer_armed_nxt = 1'b1;
        timer_rem_nxt   = time_threshold_r;
      end
      if (fire) begin
        notify_nxt      = 1'b1;
        pending_nxt     = '0;
        last_notify_nxt = time_now_r;
        timer_armed_nxt = 1'b0;
        timer_rem_nxt   = '0;
        if (mode == MODE_IMMEDIATE) begin
          immed_nxt = immed_r + 1'b1;
        end else begin
          batch_nxt = batch_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r    <= '0;
      last_notify_r <= '0;
      pending_r     <= '0;
      timer_armed_r <= 1'b0;
      timer_rem_r   <= '0;
      packets_r     <= '0;
      bytes_r       <= '0;
      calls_r       <= '0;
      batch_r       <= '0;
      immed_r       <= '0;
    end else if (in_accept) begin
      time_now_r    <= time_now_nxt;
      last_notify_r <= last_notify_nxt;
      pending_r     <= pending_nxt;
      timer_armed_r <= timer_armed_nxt;
      timer_rem_r   <= timer_rem_nxt;
      packets_r     <= packets_nxt;
      bytes_r       <= bytes_nxt;
      calls_r       <= calls_nxt;
      batch_r       <= batch_nxt;
      immed_r       <= immed_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // statistic counters shown at 32 bits
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0] packets_f, calls_f, batch_f, immed_f;

  generate
    if (STAT_WIDTH >= FIELD_W) begin : g_stat_trunc
      assign packets_f = packets_nxt[FIELD_W-1:0];
      assign calls_f   = calls_nxt[FIELD_W-1:0];
      assign batch_f   = batch_nxt[FIELD_W-1:0];
      assign immed_f   = immed_nxt[FIELD_W-1:0];
    end else begin : g_stat_ext
      assign packets_f = {{(FIELD_W-STAT_WIDTH){1'b0}}, packets_nxt};
      assign calls_f   = {{(FIELD_W-STAT_WIDTH){1'b0}}, calls_nxt};
      assign batch_f   = {{(FIELD_W-STAT_WIDTH){1'b0}}, batch_nxt};
      assign immed_f   = {{(FIELD_W-STAT_WIDTH){1'b0}}, immed_nxt};
    end
  endgenerate

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_tdata_r <= {6'd0, immed_f, batch_f, calls_f, bytes_nxt, packets_f,
                      pending_nxt, by_timer_nxt, notify_nxt};
    end
  end

`ifndef NO_ASSERTIONS
  // an armed timer always has packets waiting behind it
  a_armed_pending: assert property (@(posedge clk) disable iff (!rst_n)
    timer_armed_r |-> (pending_r != '0))
    else $error("batch timer armed with no pending packets");

  // a timer notification always clears the pending count
  a_timer_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> (out_tdata[0] && (out_tdata[17:2] == '0)))
    else $error("timer notification left packets pending");

  // each accepted tick advances time by one
  a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tuser == OP_TICK)) |=> (time_now_r == $past(time_now_r) + 1'b1))
    else $error("tick did not advance time");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of notify_coalescing_policy_top
// drives packet and tick items over the input stream, predicts each result
// item (notify decision, timer flag, pending count, statistics) in a local
// model of the coalescing policy and compares every returned item field by
// field, while both stream sides idle at random and registers change between
// phases over the register port
// ----------------------------------------------------------------------------
module tb;
  import ncp_pkg::*;

  // one predicted or observed result item
  typedef struct {
    logic        notify;
    logic        by_timer;
    logic [15:0] pending;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
    logic [31:0] call_total;
    logic [31:0] batch_total;
    logic [31:0] immediate_total;
  } policy_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [15:0] packet_size
  logic                  in_tuser;   // [0] op
  logic                  out_tvalid;
  logic                  out_tready;
  // [0] notify, [1] by_timer, [17:2] pending_count, [49:18] packet_total,
  // [97:50] byte_total, [129:98] call_total, [161:130] batch_notify_total,
  // [193:162] immediate_notify_total
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // register shadow, loaded with the reset values
  mode_t       cur_mode    = MODE_IMMEDIATE;
  logic [15:0] pkt_thr     = PACKET_THRESHOLD_RST;
  logic [15:0] time_thr    = TIME_THRESHOLD_RST;
  logic [15:0] hi_size_thr = LARGE_SIZE_RST;
  logic [15:0] lo_size_thr = SMALL_SIZE_RST;
  logic        bypass_on   = 1'b0;

  // policy state, all zero after reset
  logic [31:0] clock_ticks = '0;
  logic [31:0] last_notify = '0;
  logic [15:0] pending     = '0;
  logic        timer_on    = 1'b0;
  logic [15:0] timer_left  = '0;
  logic [31:0] pkt_cnt     = '0;
  logic [47:0] byte_cnt    = '0;
  logic [31:0] call_cnt    = '0;
  logic [31:0] batch_cnt   = '0;
  logic [31:0] imm_cnt     = '0;

  policy_result_t expected_results[$];
  int             error_count  = 0;
  int             tx_idle_pct  = 0;   // chance of a gap after each sent item
  int             rx_stall_pct = 0;   // chance of a stall run on the result side
  int             rx_hold_req  = 0;   // one long result-side hold-off, in cycles

  notify_coalescing_policy_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // safety net against a hung handshake
  initial begin
    #20000000;
    $display("tb: done, errors");
    $finish;
  end

  // coalescing decision for one item; updates the local policy state
  function automatic policy_result_t policy_step(input logic op, input logic [15:0] size);
    policy_result_t r;
    logic [31:0]    elapsed;
    logic           fire;
    fire       = 1'b0;
    r.notify   = 1'b0;
    r.by_timer = 1'b0;
    if (op == OP_TICK) begin
      clock_ticks = clock_ticks + 32'd1;
      // one-shot batch timer keeps running whatever the mode
      if (timer_on) begin
        if (timer_left <= 16'd1) begin
          timer_left = '0;
          timer_on   = 1'b0;
          if (pending != 16'd0) begin
            pending     = '0;
            last_notify = clock_ticks;
            batch_cnt   = batch_cnt + 32'd1;
            r.notify    = 1'b1;
            r.by_timer  = 1'b1;
          end
        end else begin
          timer_left = timer_left - 16'd1;
        end
      end
    end else if (bypass_on) begin
      // bypass notifies and leaves every counter alone
      r.notify = 1'b1;
    end else begin
      if (pending != PENDING_MAX) pending = pending + 16'd1;
      pkt_cnt  = pkt_cnt + 32'd1;
      byte_cnt = byte_cnt + {32'd0, size};
      elapsed  = clock_ticks - last_notify;
      case (cur_mode)
        MODE_IMMEDIATE: fire = 1'b1;
        MODE_COUNT:     fire = pending >= pkt_thr;
        MODE_TIME:      fire = elapsed >= {16'd0, time_thr};
        default: begin
          fire = size >= hi_size_thr || size < lo_size_thr ||
                 pending >= pkt_thr || elapsed >= {16'd0, time_thr};
        end
      endcase
      // first pending packet of a batch arms the timer in time and adaptive modes
      if (!fire && cur_mode >= MODE_TIME && pending == 16'd1 && !timer_on) begin
        timer_on   = 1'b1;
        timer_left = time_thr;
      end
      if (fire) begin
        pending     = '0;
        last_notify = clock_ticks;
        if (cur_mode == MODE_IMMEDIATE) imm_cnt = imm_cnt + 32'd1;
        else batch_cnt = batch_cnt + 32'd1;
        timer_on   = 1'b0;
        timer_left = '0;
      end
      call_cnt = call_cnt + 32'd1;
      r.notify = fire;
    end
    r.pending         = pending;
    r.packet_total    = pkt_cnt;
    r.byte_total      = byte_cnt;
    r.call_total      = call_cnt;
    r.batch_total     = batch_cnt;
    r.immediate_total = imm_cnt;
    return r;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // ---------------------------------------------------------------- result side
  // ready changes at the falling edge; a requested hold-off overrides the
  // random stalls and is counted down here
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0 && $urandom_range(99) < rx_stall_pct) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // every accepted result item is held against the oldest prediction
  always @(posedge clk) begin
    policy_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %0h", $time, out_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("notify", exp_r.notify, out_tdata[0]);
        check_field("by_timer", exp_r.by_timer, out_tdata[1]);
        check_field("pending_count", exp_r.pending, out_tdata[17:2]);
        check_field("packet_total", exp_r.packet_total, out_tdata[49:18]);
        check_field("byte_total", exp_r.byte_total, out_tdata[97:50]);
        check_field("call_total", exp_r.call_total, out_tdata[129:98]);
        check_field("batch_notify_total", exp_r.batch_total, out_tdata[161:130]);
        check_field("immediate_notify_total", exp_r.immediate_total, out_tdata[193:162]);
      end
    end
  end

  // ---------------------------------------------------------------- input side
  // called at a falling edge; returns at a falling edge after any gap
  task automatic send_item(input logic op, input logic [15:0] size);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= size;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(policy_step(op, size));
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
  endtask

  // stop offering items and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // two-phase register write; callers must keep the block idle, it does not check
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_NOTIFY_MODE:      cur_mode    = mode_t'(value[1:0]);
      REG_PACKET_THRESHOLD: pkt_thr     = value[15:0];
      REG_TIME_THRESHOLD:   time_thr    = value[15:0];
      REG_LARGE_SIZE:       hi_size_thr = value[15:0];
      REG_SMALL_SIZE:       lo_size_thr = value[15:0];
      REG_BYPASS:           bypass_on   = value[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input mode_t m);
    cfg_write(REG_NOTIFY_MODE, {30'd0, m});
  endtask

  // ---------------------------------------------------------------- directed
  // reset register values: every packet notifies, a lone tick does nothing
  task automatic test_immediate();
    send_item(OP_PACKET, 16'h0000);
    send_item(OP_PACKET, 16'hFFFF);
    send_item(OP_TICK, 16'hA5A5);
  endtask

  // the third pending packet reaches the threshold
  task automatic test_count_batch();
    drain();
    set_mode(MODE_COUNT);
    cfg_write(REG_PACKET_THRESHOLD, 32'd3);
    repeat (3) send_item(OP_PACKET, 16'd200);
  endtask

  // first packet arms the timer, the second tick fires it, then elapsed time
  task automatic test_time_batch();
    drain();
    set_mode(MODE_TIME);
    cfg_write(REG_TIME_THRESHOLD, 32'd2);
    send_item(OP_PACKET, 16'd300);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_PACKET, 16'd300);
  endtask

  // size at and around the large and small limits
  task automatic test_adaptive();
    drain();
    set_mode(MODE_ADAPTIVE);
    cfg_write(REG_PACKET_THRESHOLD, 32'd65535);
    cfg_write(REG_TIME_THRESHOLD, 32'd65535);
    cfg_write(REG_LARGE_SIZE, 32'd1024);
    cfg_write(REG_SMALL_SIZE, 32'd128);
    send_item(OP_PACKET, 16'd1024);
    send_item(OP_PACKET, 16'd127);
    send_item(OP_PACKET, 16'd500);
    send_item(OP_PACKET, 16'd1023);
    send_item(OP_PACKET, 16'd128);
  endtask

  // bypass packet leaves all state as is; armed adaptive timer survives it
  task automatic test_bypass();
    drain();
    cfg_write(REG_BYPASS, 32'd1);
    send_item(OP_PACKET, 16'd700);
    send_item(OP_TICK, 16'd0);
    drain();
    cfg_write(REG_BYPASS, 32'd0);
  endtask

  // a zero packet or time threshold is always met
  task automatic test_zero_thresholds();
    drain();
    set_mode(MODE_COUNT);
    cfg_write(REG_PACKET_THRESHOLD, 32'd0);
    send_item(OP_PACKET, 16'd50);
    drain();
    set_mode(MODE_TIME);
    cfg_write(REG_TIME_THRESHOLD, 32'd0);
    send_item(OP_PACKET, 16'd50);
  endtask

  // timer armed in time mode fires after a switch to count mode
  task automatic test_timer_across_mode();
    drain();
    cfg_write(REG_TIME_THRESHOLD, 32'd2);
    cfg_write(REG_PACKET_THRESHOLD, 32'd100);
    send_item(OP_PACKET, 16'd10);
    drain();
    set_mode(MODE_COUNT);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'd0);
  endtask

  // long result-side hold-off while items keep coming, then a full pause
  task automatic test_backpressure();
    drain();
    set_mode(MODE_ADAPTIVE);
    cfg_write(REG_PACKET_THRESHOLD, 32'd4);
    cfg_write(REG_TIME_THRESHOLD, 32'd3);
    tx_idle_pct = 0;
    rx_hold_req = 80;
    repeat (30) send_item(OP_PACKET, 16'($urandom_range(2000)));
    drain();
    repeat (10) send_item(OP_TICK, 16'd0);
  endtask

  // ---------------------------------------------------------------- random
  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    if (r < 24) return hi_size_thr - 16'($urandom_range(1));
    if (r < 32) return lo_size_thr - 16'($urandom_range(1));
    if (r < 60) return 16'($urandom_range(2047));
    return 16'($urandom);
  endfunction

  task automatic test_random();
    logic [15:0] pt, tt, hs, ls;
    logic        byp;
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      if (phase == 0) begin
        pt = 16'hFFFF; tt = 16'hFFFF; hs = 16'hFFFF; ls = 16'hFFFF; byp = 1'b0;
      end else if (phase == 1) begin
        pt = 16'd1; tt = 16'd1; hs = 16'd0; ls = 16'd0; byp = 1'b0;
      end else begin
        pt  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20, 1));
        tt  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12, 1));
        hs  = 16'($urandom);
        ls  = 16'($urandom_range(2000));
        byp = ($urandom_range(9) == 0);
      end
      set_mode(mode_t'($urandom_range(3)));
      cfg_write(REG_PACKET_THRESHOLD, {16'd0, pt});
      cfg_write(REG_TIME_THRESHOLD, {16'd0, tt});
      cfg_write(REG_LARGE_SIZE, {16'd0, hs});
      cfg_write(REG_SMALL_SIZE, {16'd0, ls});
      cfg_write(REG_BYPASS, {31'd0, byp});
      // odd phases run without any idling
      tx_idle_pct  = (phase % 2 == 1) ? 0 : 30;
      rx_stall_pct = (phase % 2 == 1) ? 0 : 30;
      repeat (92) begin
        if ($urandom_range(99) < 35) send_item(OP_TICK, 16'($urandom));
        else send_item(OP_PACKET, pick_size());
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    int waited;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_PACKET;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    test_immediate();
    test_count_batch();
    test_time_batch();
    test_adaptive();
    test_bypass();
    test_zero_thresholds();
    test_timer_across_mode();
    test_backpressure();
    test_random();

    // let every outstanding result come back, within a bound
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      $display("%0t: missing result item, expected one, got none", $time);
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
